// ----- design/n2d_pkg.sv -----
// Shared widths, defaults and the item classification type for the negabase converter.
package n2d_pkg;

   // Default sizes of the top level.
   localparam int DefValueWidth = 32;
   localparam int DefMaxDigits  = 33;

   // Fixed field widths.
   localparam int RadixWidth   = 5;
   localparam int DigitWidth   = 4;
   localparam int BaseWidth    = 4;
   localparam int RspDataWidth = 8;

   // Dividend bits retired per cycle by the digit divider.
   localparam int StepBits = 8;

   // Entries in the queue between front and back.
   localparam int QueueDepth = 2;

   // Legal radix range; requests outside it are clamped.
   localparam logic signed [RadixWidth-1:0] RadixMin = -5'sd10;
   localparam logic signed [RadixWidth-1:0] RadixMax = -5'sd2;

   // Sign of the value and magnitude of the clamped radix.
   typedef struct packed {
      logic                 neg;
      logic [BaseWidth-1:0] base;
   } n2d_class_type;

endpackage

// ----- design/integer_to_negabase_digits_top.sv -----
// Top level of the negative-base digit converter.
// Each request carries a signed integer and a negative radix (-10 to -2; other codes are
// clamped into that range) and produces one response transfer per digit, most significant
// digit first, with tlast on the final digit; zero gives the single digit 0. A two-entry
// queue lets the next request be taken while the engine works. The engine retires 8
// dividend bits per cycle: each digit takes one division step per 8-bit chunk of the
// value and then a finish step that writes it to the digit RAM. Playback then reads each
// digit from the RAM, loads it into the output register and holds it there until tready;
// a request gives at most MAX_DIGITS digits (33). No state survives from one request to the next.
module integer_to_negabase_digits_top #(
   parameter int VALUE_WIDTH = n2d_pkg::DefValueWidth,
   parameter int MAX_DIGITS  = n2d_pkg::DefMaxDigits
) (
   input  logic clock,
   input  logic reset,
   // req_tdata: value [VALUE_WIDTH-1:0], radix [VALUE_WIDTH+4:VALUE_WIDTH], zero fill above
   input  logic                                                    req_tvalid,
   output logic                                                    req_tready,
   input  logic [((VALUE_WIDTH+n2d_pkg::RadixWidth+7)/8)*8-1:0]    req_tdata,
   // rsp_tdata: digit [3:0], zero fill above
   output logic                                                    rsp_tvalid,
   input  logic                                                    rsp_tready,
   output logic [n2d_pkg::RspDataWidth-1:0]                        rsp_tdata,
   output logic                                                    rsp_tlast
);
   import n2d_pkg::*;

   localparam int ItemW = VALUE_WIDTH + $bits(n2d_class_type);

   n2d_class_type          front_cls;
   logic [VALUE_WIDTH-1:0] front_mag;
   logic                   q_valid;
   logic                   q_ready;
   logic [ItemW-1:0]       q_data;
   n2d_class_type          back_cls;
   logic [VALUE_WIDTH-1:0] back_mag;
   logic [DigitWidth-1:0]  digit;

   // Classify the incoming request.
   n2d_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .value (req_tdata[VALUE_WIDTH-1:0]),
      .radix (req_tdata[VALUE_WIDTH +: RadixWidth]),
      .cls   (front_cls),
      .mag   (front_mag)
   );

   // Queue between classification and conversion.
   n2d_queue #(
      .WIDTH (ItemW),
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  ({front_mag, front_cls}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign back_cls = q_data[$bits(n2d_class_type)-1:0];
   assign back_mag = q_data[ItemW-1 -: VALUE_WIDTH];

   // Digit conversion and playback.
   n2d_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item_cls   (back_cls),
      .item_mag   (back_mag),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_digit  (digit),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RspDataWidth'(digit);

endmodule

// ----- design/n2d_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module n2d_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/n2d_front.sv -----
// Front end: splits the sign from the value and clamps the radix to its legal range.
module n2d_front #(
   parameter int VALUE_WIDTH = n2d_pkg::DefValueWidth
) (
   input  logic [VALUE_WIDTH-1:0]         value,
   input  logic [n2d_pkg::RadixWidth-1:0] radix,
   output n2d_pkg::n2d_class_type         cls,
   output logic [VALUE_WIDTH-1:0]         mag
);
   import n2d_pkg::*;

   logic signed [RadixWidth-1:0] radix_s;
   logic signed [RadixWidth-1:0] radix_sat;
   logic signed [RadixWidth-1:0] radix_neg;

   assign radix_s = radix;

   // Clamp the radix and take its magnitude.
   always_comb begin
      if (radix_s < RadixMin) begin
         radix_sat = RadixMin;
      end else if (radix_s > RadixMax) begin
         radix_sat = RadixMax;
      end else begin
         radix_sat = radix_s;
      end
      radix_neg = -radix_sat;
   end

   assign cls.base = radix_neg[BaseWidth-1:0];

   // Sign and unsigned magnitude; the most negative value maps to its true magnitude.
   assign cls.neg = value[VALUE_WIDTH-1];
   assign mag     = cls.neg ? (~value + VALUE_WIDTH'(1)) : value;

endmodule

// ----- design/n2d_queue.sv -----
// Small FIFO that decouples the front end from the conversion engine.
module n2d_queue #(
   parameter int WIDTH = 37,
   parameter int DEPTH = n2d_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CntW'(DEPTH));
   assign pop_valid  = (cnt_ff != CntW'(0));
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? PtrW'(0) : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? PtrW'(0) : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/n2d_back.sv -----
// Conversion engine: divides out one negabase digit at a time, then plays the digits back.
module n2d_back #(
   parameter int VALUE_WIDTH = n2d_pkg::DefValueWidth,
   parameter int MAX_DIGITS  = n2d_pkg::DefMaxDigits
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  n2d_pkg::n2d_class_type         item_cls,
   input  logic [VALUE_WIDTH-1:0]         item_mag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [n2d_pkg::DigitWidth-1:0] rsp_digit,
   output logic                           rsp_last
);
   import n2d_pkg::*;

   localparam int Chunks = (VALUE_WIDTH + StepBits - 1) / StepBits;
   localparam int PadW   = Chunks * StepBits;
   localparam int ChunkW = $clog2(Chunks + 1);
   localparam int AddrW  = $clog2(MAX_DIGITS);
   localparam int CntW   = $clog2(MAX_DIGITS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_FIN,
      S_READ,
      S_LOAD,
      S_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [BaseWidth-1:0]  base_ff, base_in;
   logic [PadW-1:0]       num_ff, num_in;
   logic [BaseWidth-1:0]  rem_ff, rem_in;
   logic [ChunkW-1:0]     chunk_ff, chunk_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [AddrW-1:0]      ptr_ff, ptr_in;
   logic [DigitWidth-1:0] digit_ff, digit_in;
   logic                  last_ff, last_in;
   logic                  valid_ff, valid_in;

   logic [StepBits-1:0]    top_bits;
   logic [StepBits-1:0]    q_bits;
   logic [BaseWidth-1:0]   r_acc;
   logic [BaseWidth:0]     r_try;
   logic [VALUE_WIDTH-1:0] q_mag;
   logic [VALUE_WIDTH-1:0] mag_next;
   logic [DigitWidth-1:0]  fin_digit;
   logic [DigitWidth-1:0]  rd_data;

   // Restoring division of the top dividend bits by the small base magnitude.
   always_comb begin
      top_bits = num_ff[PadW-1 -: StepBits];
      r_acc    = rem_ff;
      r_try    = '0;
      q_bits   = '0;
      for (int i = StepBits - 1; i >= 0; i--) begin
         r_try = {r_acc, top_bits[i]};
         if (r_try >= {1'b0, base_ff}) begin
            r_try     = r_try - {1'b0, base_ff};
            q_bits[i] = 1'b1;
         end
         r_acc = r_try[BaseWidth-1:0];
      end
   end

   // Fold the unsigned quotient and remainder into the negabase digit and next magnitude.
   // A negative dividend with a nonzero remainder borrows one from the quotient.
   always_comb begin
      q_mag = num_ff[VALUE_WIDTH-1:0];
      if (neg_ff && (rem_ff != '0)) begin
         fin_digit = DigitWidth'(base_ff - rem_ff);
         mag_next  = q_mag + VALUE_WIDTH'(1);
      end else begin
         fin_digit = DigitWidth'(rem_ff);
         mag_next  = q_mag;
      end
   end

   // Digit stack, least significant digit at address zero.
   n2d_ram #(
      .WIDTH (DigitWidth),
      .DEPTH (MAX_DIGITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_FIN),
      .wr_addr (cnt_ff[AddrW-1:0]),
      .wr_data (fin_digit),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      base_in  = base_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      digit_in = digit_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               neg_in   = item_cls.neg;
               base_in  = item_cls.base;
               num_in   = PadW'(item_mag);
               rem_in   = '0;
               chunk_in = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            num_in   = (num_ff << StepBits) | PadW'(q_bits);
            rem_in   = r_acc;
            chunk_in = chunk_ff + ChunkW'(1);
            if (chunk_ff == ChunkW'(Chunks - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cnt_in = cnt_ff + CntW'(1);
            if ((mag_next == '0) || (cnt_ff == CntW'(MAX_DIGITS - 1))) begin
               ptr_in   = cnt_ff[AddrW-1:0];
               state_in = S_READ;
            end else begin
               neg_in   = !neg_ff;
               num_in   = PadW'(mag_next);
               rem_in   = '0;
               chunk_in = '0;
               state_in = S_DIV;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            digit_in = rd_data;
            last_in  = (ptr_ff == '0);
            valid_in = 1'b1;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff - AddrW'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         chunk_ff <= chunk_in;
         cnt_ff   <= cnt_in;
         ptr_ff   <= ptr_in;
         digit_ff <= digit_in;
         last_ff  <= last_in;
      end
   end

   assign item_ready = (state_ff == S_IDLE);
   assign rsp_valid  = valid_ff;
   assign rsp_digit  = digit_ff;
   assign rsp_last   = last_ff;

endmodule

// ----- design/n2d_check.sv -----
// Port-level checks for the negabase converter, bound to its top level.
module n2d_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [n2d_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   // A stalled response holds its digit and last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Every digit is a decimal-range digit with zero fill above it.
   a_rsp_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] <= 4'd9) && (rsp_tdata[7:4] == 4'd0))
      else $error("response digit out of range");

   // The output register empties after every transfer before the next digit is fetched.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("response valid right after a transfer");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind integer_to_negabase_digits_top n2d_check u_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
